/* sv/dtq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int TMR_NUM   = 16;
  localparam int TMR_IDX_W = (TMR_NUM > 1) ? $clog2(TMR_NUM) : 1;
  localparam int TMR_CNT_W = $clog2(TMR_NUM + 1);
  localparam int DL_W      = 48;
  localparam int RELOAD_W  = 32;

  localparam logic [RELOAD_W-1:0] IDLE_RELOAD_RST = 32'd1000;

  localparam logic [1:0] MODE_ARM    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

endpackage
`default_nettype wire

/* sv/deadline_timer_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_queue
// One-shot timers ordered by absolute deadline; arm, cancel and tick.
// ----------------------------------------------------------------------------
// arm, cancel and idle ticks pass through update, a scan of the deadline RAM, decision
//   and the output register before their result appears
// a tick firing k timers rescans after each fired timer and reports each one after the next scan;
//   one item at a time, busy falls as the last result registers
// synchronous reset clears the marks and sets idle_reload_ms to 1000; deadline RAM not cleared
// results cannot be stalled
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_mode,
  input  wire logic [3:0]          in_timer_slot,
  input  wire logic [31:0]         in_elapse_ms,
  input  wire logic [47:0]         in_now_ms,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_idle_reload_ms,
  output logic                     out_valid,
  output logic                     out_fired,
  output logic [3:0]               out_fired_slot,
  output logic [31:0]              out_clock_reload,
  output logic                     out_bad_cancel,
  output logic                     out_last
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]           state_r;
  logic [1:0]           mode_r;
  logic [3:0]           slot_r;
  logic [DL_W-1:0]      now_r;
  logic [DL_W-1:0]      arm_dl_r;
  logic                 bad_r;
  logic [TMR_NUM-1:0]   active_r;
  logic [TMR_NUM-1:0]   fired_r;
  logic [TMR_CNT_W-1:0] cnt_r;
  logic                 found_r;
  logic [TMR_IDX_W-1:0] best_idx_r;
  logic [DL_W-1:0]      best_dl_r;
  logic                 pend_r;
  logic [TMR_IDX_W-1:0] pend_slot_r;
  logic [RELOAD_W-1:0]  idle_reload_r;

  logic                 out_valid_r;
  logic                 out_fired_r;
  logic [3:0]           out_fired_slot_r;
  logic [RELOAD_W-1:0]  out_clock_reload_r;
  logic                 out_bad_cancel_r;
  logic                 out_last_r;

  logic                 accept;
  logic [DL_W:0]        arm_sum;
  logic                 in_range;
  logic [TMR_IDX_W-1:0] slot_idx;
  logic                 ram_we;
  logic [DL_W-1:0]      ram_rdata;
  logic [TMR_IDX_W-1:0] scan_idx;
  logic                 scan_take;
  logic                 due;
  logic [DL_W-1:0]      diff;
  logic [RELOAD_W-1:0]  reload_calc;
  logic                 cancel_bad;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign arm_sum  = {1'b0, in_now_ms} + (DL_W + 1)'(in_elapse_ms);
  assign in_range = (32'(slot_r) < 32'(TMR_NUM));
  assign slot_idx = TMR_IDX_W'(slot_r);
  assign ram_we   = (state_r == ST_UPDATE) && (mode_r == MODE_ARM) && in_range;
  assign cancel_bad = !in_range || !active_r[slot_idx] || fired_r[slot_idx];

  assign scan_idx  = TMR_IDX_W'(cnt_r - TMR_CNT_W'(1));
  assign scan_take = (cnt_r != '0) && active_r[scan_idx] &&
                     (!found_r || (ram_rdata < best_dl_r));

  assign due  = found_r && (best_dl_r <= now_r);
  assign diff = best_dl_r - now_r;

  always_comb begin
    if (!found_r) begin
      reload_calc = idle_reload_r;
    end else if (due) begin
      reload_calc = '0;
    end else if (diff[DL_W-1:RELOAD_W] != '0) begin
      reload_calc = '1;
    end else begin
      reload_calc = diff[RELOAD_W-1:0];
    end
  end

  dtq_ram #(
    .WIDTH (DL_W),
    .DEPTH (TMR_NUM)
  ) u_dl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (arm_dl_r),
    .raddr (cnt_r[TMR_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // control path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      active_r      <= '0;
      fired_r       <= '0;
      out_valid_r   <= 1'b0;
      idle_reload_r <= IDLE_RELOAD_RST;
    end else begin
      out_valid_r <= (state_r == ST_DONE) &&
                     ((mode_r != MODE_TICK) || pend_r || !due);
      if (cfg_we) begin
        idle_reload_r <= cfg_idle_reload_ms;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (ram_we) begin
            active_r[slot_idx] <= 1'b1;
            fired_r[slot_idx]  <= 1'b0;
          end
          if ((mode_r == MODE_CANCEL) && !cancel_bad) begin
            active_r[slot_idx] <= 1'b0;
          end
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cnt_r == TMR_CNT_W'(TMR_NUM)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if ((mode_r == MODE_TICK) && due) begin
            active_r[best_idx_r] <= 1'b0;
            fired_r[best_idx_r]  <= 1'b1;
            state_r              <= ST_SCAN;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // data path
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_r   <= in_mode;
          slot_r   <= in_timer_slot;
          now_r    <= in_now_ms;
          arm_dl_r <= arm_sum[DL_W] ? '1 : arm_sum[DL_W-1:0];
          bad_r    <= 1'b0;
          pend_r   <= 1'b0;
        end
      end
      ST_UPDATE: begin
        if (mode_r == MODE_CANCEL) begin
          bad_r <= cancel_bad;
        end
        cnt_r   <= '0;
        found_r <= 1'b0;
      end
      ST_SCAN: begin
        cnt_r <= cnt_r + TMR_CNT_W'(1);
        if (scan_take) begin
          found_r    <= 1'b1;
          best_idx_r <= scan_idx;
          best_dl_r  <= ram_rdata;
        end
      end
      ST_DONE: begin
        cnt_r   <= '0;
        found_r <= 1'b0;
        if (mode_r == MODE_TICK) begin
          out_fired_r        <= pend_r;
          out_fired_slot_r   <= pend_r ? 4'(pend_slot_r) : 4'd0;
          out_clock_reload_r <= pend_r ? reload_calc : idle_reload_r;
          out_bad_cancel_r   <= 1'b0;
          out_last_r         <= !due;
          if (due) begin
            pend_r      <= 1'b1;
            pend_slot_r <= best_idx_r;
          end
        end else begin
          out_fired_r        <= 1'b0;
          out_fired_slot_r   <= 4'd0;
          out_clock_reload_r <= reload_calc;
          out_bad_cancel_r   <= (mode_r == MODE_CANCEL) && bad_r;
          out_last_r         <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_fired_slot   = out_fired_slot_r;
  assign out_clock_reload = out_clock_reload_r;
  assign out_bad_cancel   = out_bad_cancel_r;
  assign out_last         = out_last_r;

endmodule
`default_nettype wire

/* sv/dtq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/dtq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks for the deadline timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_fired,
  input wire logic [3:0]  out_fired_slot,
  input wire logic        out_bad_cancel,
  input wire logic        out_last
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-final result while idle");

  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> (out_last && (out_fired_slot == 4'd0)))
    else $error("non-fired result not single or slot set");

  a_fired_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fired && out_bad_cancel))
    else $error("fired and bad cancel together");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_fired      (out_fired),
  .out_fired_slot (out_fired_slot),
  .out_bad_cancel (out_bad_cancel),
  .out_last       (out_last)
);
`default_nettype wire

/* test/deadline_timer_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_tb
// Feeds arm, cancel and tick commands with random gaps, keeps its own table
// of deadlines and marks, and checks every strobed report field by field.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb;
  import dtq_pkg::*;

  localparam logic [1:0]      MODE_NONE   = 2'd3;
  localparam int              SETTLE_CYC  = TMR_NUM + 8;
  localparam int              DRAIN_CYC   = 2 * TMR_NUM + 16;
  localparam int              CYCLE_LIMIT = 400000;
  localparam int              RANDOM_OPS  = 220;
  localparam logic [DL_W-1:0] DL_MAX      = '1;

  typedef struct packed {
    logic                fired;
    logic [3:0]          fired_slot;
    logic [RELOAD_W-1:0] reload;
    logic                bad_cancel;
    logic                last;
  } report_t;

  typedef struct {
    bit                  is_cfg;
    logic [1:0]          mode;
    logic [3:0]          slot;
    logic [31:0]         elapse;
    logic [DL_W-1:0]     now;
    logic [RELOAD_W-1:0] cfg_value;
    int                  gap;
  } op_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_mode = '0;
  logic [3:0]          in_timer_slot = '0;
  logic [31:0]         in_elapse_ms = '0;
  logic [47:0]         in_now_ms = '0;
  logic                cfg_we = 1'b0;
  logic [31:0]         cfg_idle_reload_ms = '0;
  logic                out_valid;
  logic                out_fired;
  logic [3:0]          out_fired_slot;
  logic [31:0]         out_clock_reload;
  logic                out_bad_cancel;
  logic                out_last;

  // timer table as the block should hold it
  logic [DL_W-1:0]     deadline_m [TMR_NUM] = '{default: '0};
  bit                  active_m   [TMR_NUM] = '{default: 1'b0};
  bit                  fired_m    [TMR_NUM] = '{default: 1'b0};
  logic [RELOAD_W-1:0] idle_reload_m = IDLE_RELOAD_RST;

  op_t     op_queue [$];
  report_t awaited [$];

  int accept_cnt  = 0;
  int issue_cnt   = 0;
  int gap_left    = 0;
  int settle_left = SETTLE_CYC;
  int err_cnt     = 0;
  int cycle_cnt   = 0;
  int made        = 0;
  bit quiet_phase = 1'b0;

  deadline_timer_queue dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_timer_slot      (in_timer_slot),
    .in_elapse_ms       (in_elapse_ms),
    .in_now_ms          (in_now_ms),
    .cfg_we             (cfg_we),
    .cfg_idle_reload_ms (cfg_idle_reload_ms),
    .out_valid          (out_valid),
    .out_fired          (out_fired),
    .out_fired_slot     (out_fired_slot),
    .out_clock_reload   (out_clock_reload),
    .out_bad_cancel     (out_bad_cancel),
    .out_last           (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < TMR_NUM; i++) begin
      if (active_m[i] && (best < 0 || deadline_m[i] < deadline_m[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic logic [RELOAD_W-1:0] reload_at(input logic [DL_W-1:0] now);
    int              e;
    logic [DL_W-1:0] diff;
    e = earliest_slot();
    if (e < 0) return idle_reload_m;
    if (deadline_m[e] <= now) return '0;
    diff = deadline_m[e] - now;
    if (diff[DL_W-1:RELOAD_W] != '0) return '1;
    return diff[RELOAD_W-1:0];
  endfunction

  task automatic step_timers(input logic [1:0] mode, input logic [3:0] slot,
                             input logic [31:0] elapse, input logic [DL_W-1:0] now);
    logic [DL_W:0] sum;
    report_t       tail;
    int            e;
    bit            bad;
    bit            any;
    any = 1'b0;
    case (mode)
      MODE_ARM: begin
        sum = {1'b0, now} + {{(DL_W-31){1'b0}}, elapse};
        deadline_m[slot] = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
        fired_m[slot] = 1'b0;
        active_m[slot] = 1'b1;
        awaited.push_back({1'b0, 4'd0, reload_at(now), 1'b0, 1'b1});
      end
      MODE_CANCEL: begin
        bad = !active_m[slot] || fired_m[slot];
        if (!bad) active_m[slot] = 1'b0;
        awaited.push_back({1'b0, 4'd0, reload_at(now), bad, 1'b1});
      end
      MODE_TICK: begin
        e = earliest_slot();
        while (e >= 0 && deadline_m[e] <= now) begin
          active_m[e] = 1'b0;
          fired_m[e] = 1'b1;
          awaited.push_back({1'b1, 4'(e), reload_at(now), 1'b0, 1'b0});
          any = 1'b1;
          e = earliest_slot();
        end
        if (any) begin
          tail = awaited.pop_back();
          tail.last = 1'b1;
          awaited.push_back(tail);
        end else begin
          awaited.push_back({1'b0, 4'd0, idle_reload_m, 1'b0, 1'b1});
        end
      end
      default: begin
        awaited.push_back({1'b0, 4'd0, reload_at(now), 1'b0, 1'b1});
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_op(input logic [1:0] mode, input logic [3:0] slot,
                        input logic [31:0] elapse, input logic [DL_W-1:0] now);
    op_t op;
    op = '{1'b0, mode, slot, elapse, now, '0, pick_gap()};
    op_queue.push_back(op);
    made++;
  endtask

  task automatic add_cfg(input logic [RELOAD_W-1:0] value);
    op_t op;
    op = '{1'b1, MODE_NONE, 4'd0, 32'd0, '0, value, pick_gap()};
    op_queue.push_back(op);
  endtask

  // driver: one command or register write per transfer, inputs change on the falling edge
  always @(negedge clk) begin : drive
    op_t  op;
    logic nxt_start;
    logic nxt_we;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (rst_n) begin
      if (accept_cnt != issue_cnt) begin
        nxt_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (op_queue.size() > 0) begin
        op = op_queue[0];
        if (!op.is_cfg) begin
          void'(op_queue.pop_front());
          in_mode <= op.mode;
          in_timer_slot <= op.slot;
          in_elapse_ms <= op.elapse;
          in_now_ms <= op.now;
          nxt_start = 1'b1;
          issue_cnt = issue_cnt + 1;
          gap_left = op.gap;
        end else if (busy || awaited.size() != 0) begin
          settle_left = SETTLE_CYC;
        end else if (settle_left > 0) begin
          settle_left = settle_left - 1;
        end else begin
          void'(op_queue.pop_front());
          cfg_idle_reload_ms <= op.cfg_value;
          nxt_we = 1'b1;
          gap_left = op.gap;
          settle_left = SETTLE_CYC;
        end
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  // monitor: check reports, then fold accepted transfers into the table
  always @(posedge clk) begin : watch
    report_t got;
    report_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_fired, out_fired_slot, out_clock_reload, out_bad_cancel, out_last};
        if (awaited.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected report: fired=%0b slot=%0d reload=%0d bad=%0b last=%0b",
                     got.fired, got.fired_slot, got.reload, got.bad_cancel, got.last);
          end
        end else begin
          want = awaited.pop_front();
          if (got.fired !== want.fired || got.fired_slot !== want.fired_slot ||
              got.reload !== want.reload || got.bad_cancel !== want.bad_cancel ||
              got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: exp fired=%0b slot=%0d reload=%0d bad=%0b last=%0b",
                       want.fired, want.fired_slot, want.reload, want.bad_cancel,
                       want.last);
              $display("          got fired=%0b slot=%0d reload=%0d bad=%0b last=%0b",
                       got.fired, got.fired_slot, got.reload, got.bad_cancel, got.last);
            end
          end
        end
      end
      if (cfg_we) idle_reload_m = cfg_idle_reload_ms;
      if (start && !busy) begin
        step_timers(in_mode, in_timer_slot, in_elapse_ms, in_now_ms);
        accept_cnt <= accept_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("deadline_timer_queue_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DL_W-1:0] t;
    logic [3:0]      slot;
    logic [31:0]     elapse;
    int              n;
    int              r;
    int              episode;
    bit              full;

    // directed: idle paths, ties, rearm, bad cancels, saturation
    add_op(MODE_TICK, 4'd9, 32'd0, 48'd0);
    add_op(MODE_NONE, 4'd4, 32'd77, 48'd5);
    add_op(MODE_CANCEL, 4'd3, 32'd0, 48'd10);
    add_op(MODE_ARM, 4'd0, 32'd0, 48'd100);
    add_op(MODE_ARM, 4'd15, 32'd50, 48'd100);
    add_op(MODE_ARM, 4'd7, 32'd50, 48'd100);
    add_op(MODE_TICK, 4'd0, 32'd0, 48'd150);
    add_op(MODE_CANCEL, 4'd7, 32'd0, 48'd160);
    add_op(MODE_ARM, 4'd7, 32'd20, 48'd200);
    add_op(MODE_ARM, 4'd7, 32'd40, 48'd200);
    add_op(MODE_ARM, 4'd12, 32'd90, 48'd210);
    add_op(MODE_CANCEL, 4'd7, 32'd0, 48'd220);
    add_op(MODE_CANCEL, 4'd12, 32'd0, 48'd230);
    add_op(MODE_ARM, 4'd1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF0);
    add_op(MODE_NONE, 4'd0, 32'd0, 48'd0);
    add_op(MODE_ARM, 4'd2, 32'hFFFF_FFFF, 48'd1000);
    add_op(MODE_TICK, 4'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
    add_cfg(32'd0);
    add_op(MODE_TICK, 4'd5, 32'd0, 48'd300);
    add_op(MODE_CANCEL, 4'd5, 32'd0, 48'd300);
    add_cfg(32'hFFFF_FFFF);
    add_op(MODE_ARM, 4'd4, 32'd3, 48'h8000_0000_0000);
    add_op(MODE_TICK, 4'd0, 32'd0, 48'h8000_0000_0001);
    add_op(MODE_TICK, 4'd0, 32'd0, 48'h8000_0000_0003);
    add_cfg(IDLE_RELOAD_RST);

    t = 48'd1000;
    episode = 0;
    n = made + RANDOM_OPS;
    while (made < n) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      if (episode % 6 == 5) begin
        case ($urandom_range(0, 3))
          0: add_cfg('0);
          1: add_cfg('1);
          2: add_cfg(IDLE_RELOAD_RST);
          default: add_cfg($urandom);
        endcase
      end
      r = $urandom_range(0, 9);
      if (r < 2) begin
        repeat ($urandom_range(1, 4)) begin
          add_op(2'($urandom_range(0, 3)), 4'($urandom), $urandom,
                 {16'($urandom), 32'($urandom)});
        end
      end else begin
        if ($urandom_range(0, 7) == 0) t = {16'($urandom), 32'($urandom)};
        full = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < (full ? TMR_NUM : $urandom_range(1, 6)); k++) begin
          slot = full ? 4'(k) : 4'($urandom);
          if (full) elapse = $urandom_range(0, 40);
          else if ($urandom_range(0, 9) == 0) elapse = $urandom;
          else elapse = $urandom_range(0, 120);
          t = t + $urandom_range(0, 5);
          add_op(MODE_ARM, slot, elapse, t);
        end
        repeat ($urandom_range(0, 2)) add_op(MODE_CANCEL, 4'($urandom), $urandom, t);
        if ($urandom_range(0, 5) == 0) add_op(MODE_NONE, 4'($urandom), $urandom, t);
        if (full) t = t + 100;
        repeat ($urandom_range(1, 4)) begin
          t = t + $urandom_range(0, 90);
          add_op(MODE_TICK, 4'($urandom), $urandom, t);
        end
      end
      episode++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (op_queue.size() != 0 || accept_cnt != issue_cnt) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (awaited.size() != 0) begin
      err_cnt++;
      $display("%0d reports never arrived", awaited.size());
    end
    if (err_cnt == 0) begin
      $display("deadline_timer_queue_tb passed");
    end else begin
      $display("deadline_timer_queue_tb failed");
    end
    $finish;
  end

endmodule
